>>> src/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg
// shared constants, register codes and types of the tile transpose buffer
// ----------------------------------------------------------------------------
package ttb_pkg;

	localparam int MaxTileRowsDefault = 64;
	localparam int MaxTileColsDefault = 64;
	localparam int WordBitsDefault    = 32;

	localparam int InWordBits  = 32;
	localparam int OutWordBits = 32;
	localparam int CfgDataBits = 7;
	localparam int CfgIndexBits = 2;

	localparam int MinTileSize   = 4;
	localparam int ResetTileSize = 64;

	localparam logic [CfgIndexBits-1:0] REG_TILE_ROWS       = 2'd0;
	localparam logic [CfgIndexBits-1:0] REG_TILE_COLS       = 2'd1;
	localparam logic [CfgIndexBits-1:0] REG_REVERSE_COLUMNS = 2'd2;

	typedef struct packed {
		logic valid;
		logic tile_end;
	} status_t;

	function automatic int clamp_size(input logic [CfgDataBits-1:0] v, input int hi);
		int r;
		r = int'(v);
		if (r < MinTileSize) begin
			r = MinTileSize;
		end else if (r > hi) begin
			r = hi;
		end
		return r;
	endfunction

endpackage

>>> src/ttb_store.sv
// ----------------------------------------------------------------------------
// ttb_store
// ping-pong word store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module ttb_store #(
	parameter int ADDR_BITS = 13,
	parameter int WORD_BITS = ttb_pkg::WordBitsDefault
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  logic [WORD_BITS-1:0] wr_data,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output logic [WORD_BITS-1:0] rd_data
);

	localparam int Depth = 1 << ADDR_BITS;

	logic [WORD_BITS-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> src/ttb_addr_gen.sv
// ----------------------------------------------------------------------------
// ttb_addr_gen
// tile size registers, write and transposed read positions, bank control
// ----------------------------------------------------------------------------
module ttb_addr_gen #(
	parameter int MAX_TILE_ROWS = ttb_pkg::MaxTileRowsDefault,
	parameter int MAX_TILE_COLS = ttb_pkg::MaxTileColsDefault,
	localparam int RB = $clog2(MAX_TILE_ROWS),
	localparam int CB = $clog2(MAX_TILE_COLS),
	localparam int AB = 1 + RB + CB
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ttb_pkg::CfgIndexBits-1:0]    cfg_index,
	input  logic [ttb_pkg::CfgDataBits-1:0]     cfg_data,
	input  logic                                accept,
	output logic [AB-1:0]                       rd_addr,
	output logic [AB-1:0]                       wr_addr,
	output ttb_pkg::status_t                    status
);

	localparam int SRB = $clog2(MAX_TILE_ROWS + 1);
	localparam int SCB = $clog2(MAX_TILE_COLS + 1);
	localparam int RowsReset = (MAX_TILE_ROWS < ttb_pkg::ResetTileSize) ?
		MAX_TILE_ROWS : ttb_pkg::ResetTileSize;
	localparam int ColsReset = (MAX_TILE_COLS < ttb_pkg::ResetTileSize) ?
		MAX_TILE_COLS : ttb_pkg::ResetTileSize;

	logic [SRB-1:0] rows_q;
	logic [SCB-1:0] cols_q;
	logic           reverse_q;
	logic [RB-1:0]  wr_row_q, rd_row_q;
	logic [CB-1:0]  wr_col_q, rd_col_q;
	logic           bank_q;
	logic           ready_q;

	logic           size_write;
	logic [SCB-1:0] rev_col;
	logic [CB-1:0]  rd_col_eff;
	logic           rd_row_wrap, rd_col_wrap, wr_col_wrap, wr_row_wrap;

	assign size_write = cfg_we &&
		(cfg_index == ttb_pkg::REG_TILE_ROWS || cfg_index == ttb_pkg::REG_TILE_COLS);

	always_comb begin
		rev_col     = cols_q - SCB'(1) - SCB'(rd_col_q);
		rd_col_eff  = reverse_q ? rev_col[CB-1:0] : rd_col_q;
		rd_row_wrap = (SRB'(rd_row_q) + SRB'(1)) >= rows_q;
		rd_col_wrap = (SCB'(rd_col_q) + SCB'(1)) >= cols_q;
		wr_col_wrap = (SCB'(wr_col_q) + SCB'(1)) >= cols_q;
		wr_row_wrap = (SRB'(wr_row_q) + SRB'(1)) >= rows_q;
		rd_addr     = {~bank_q, rd_row_q, rd_col_eff};
		wr_addr     = {bank_q, wr_row_q, wr_col_q};
		status.valid    = ready_q;
		status.tile_end = ready_q && rd_row_wrap && rd_col_wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q    <= SRB'(RowsReset);
			cols_q    <= SCB'(ColsReset);
			reverse_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ttb_pkg::REG_TILE_ROWS: begin
					rows_q <= SRB'(ttb_pkg::clamp_size(cfg_data, MAX_TILE_ROWS));
				end
				ttb_pkg::REG_TILE_COLS: begin
					cols_q <= SCB'(ttb_pkg::clamp_size(cfg_data, MAX_TILE_COLS));
				end
				ttb_pkg::REG_REVERSE_COLUMNS: begin
					reverse_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_row_q <= '0;
			wr_col_q <= '0;
			rd_row_q <= '0;
			rd_col_q <= '0;
			bank_q   <= 1'b0;
			ready_q  <= 1'b0;
		end else if (size_write) begin
			wr_row_q <= '0;
			wr_col_q <= '0;
			rd_row_q <= '0;
			rd_col_q <= '0;
			ready_q  <= 1'b0;
		end else if (accept) begin
			// transposed read walks rows inside a column
			if (ready_q) begin
				if (rd_row_wrap) begin
					rd_row_q <= '0;
					rd_col_q <= rd_col_wrap ? '0 : rd_col_q + CB'(1);
				end else begin
					rd_row_q <= rd_row_q + RB'(1);
				end
			end
			if (wr_col_wrap) begin
				wr_col_q <= '0;
				if (wr_row_wrap) begin
					// tile complete: swap banks, restart the read side
					wr_row_q <= '0;
					bank_q   <= ~bank_q;
					ready_q  <= 1'b1;
					rd_row_q <= '0;
					rd_col_q <= '0;
				end else begin
					wr_row_q <= wr_row_q + RB'(1);
				end
			end else begin
				wr_col_q <= wr_col_q + CB'(1);
			end
		end
	end

	a_size_restart: assert property (@(posedge clk) disable iff (!arst_n)
		size_write |=> (wr_row_q == '0 && wr_col_q == '0 && rd_row_q == '0 &&
			rd_col_q == '0 && !ready_q))
		else $error("size write did not restart the stream");

	a_pos_in_tile: assert property (@(posedge clk) disable iff (!arst_n)
		(SRB'(wr_row_q) < rows_q) && (SCB'(wr_col_q) < cols_q) &&
		(SRB'(rd_row_q) < rows_q) && (SCB'(rd_col_q) < cols_q))
		else $error("position outside the tile");

	a_tile_swap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !size_write && wr_col_wrap && wr_row_wrap) |=>
			(ready_q && bank_q != $past(bank_q) && rd_row_q == '0 && rd_col_q == '0))
		else $error("bank swap missed at tile end");

	a_idle_read: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !ready_q && !size_write) |=> (rd_row_q == '0 && rd_col_q == '0))
		else $error("read position moved before a tile was ready");

endmodule

>>> src/tile_transpose_buffer.sv
// ----------------------------------------------------------------------------
// tile_transpose_buffer
// double-buffered transpose of row-major word tiles
// ----------------------------------------------------------------------------
// Takes one word per cycle and returns one item per input word; throughput is
// one item per cycle unless stalled, set by the single write port and single
// read port of the ping-pong store (2 x MAX_TILE_ROWS x MAX_TILE_COLS
// words, sized to powers of two). Each input word is written into the
// current bank while the word of the previous tile in transposed order is
// read from the other bank. Until the first tile is complete, items carry
// tuser = 0 and a zero word. tlast marks the last word of an output tile.
// Writing tile_rows or tile_cols restarts the stream.
module tile_transpose_buffer #(
	parameter int MAX_TILE_ROWS = ttb_pkg::MaxTileRowsDefault,
	parameter int MAX_TILE_COLS = ttb_pkg::MaxTileColsDefault,
	parameter int WORD_BITS     = ttb_pkg::WordBitsDefault
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ttb_pkg::CfgIndexBits-1:0]    cfg_index,
	input  logic [ttb_pkg::CfgDataBits-1:0]     cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [ttb_pkg::InWordBits-1:0]      s_tdata,  // in_word
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [ttb_pkg::OutWordBits-1:0]     m_tdata,  // out_word
	output logic                                m_tuser,  // out_valid
	output logic                                m_tlast   // out_tile_end
);

	localparam int AB = 1 + $clog2(MAX_TILE_ROWS) + $clog2(MAX_TILE_COLS);

	logic                 accept;
	logic [AB-1:0]        rd_addr, wr_addr;
	logic [WORD_BITS-1:0] rd_data;
	ttb_pkg::status_t     status;
	ttb_pkg::status_t     status_q;
	logic                 out_valid_q;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	ttb_addr_gen #(
		.MAX_TILE_ROWS(MAX_TILE_ROWS),
		.MAX_TILE_COLS(MAX_TILE_COLS)
	) u_addr_gen (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.status   (status)
	);

	ttb_store #(
		.ADDR_BITS(AB),
		.WORD_BITS(WORD_BITS)
	) u_store (
		.clk    (clk),
		.we     (accept),
		.wr_addr(wr_addr),
		.wr_data(WORD_BITS'(s_tdata)),
		.re     (accept),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = status_q.valid ? ttb_pkg::OutWordBits'(rd_data) : '0;
	assign m_tuser  = status_q.valid;
	assign m_tlast  = status_q.tile_end;

	a_last_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tuser)
		else $error("tile end on an item without a ready tile");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted item produced no output");

endmodule

>>> tb/sv/ttb_checker.sv
// ----------------------------------------------------------------------------
// ttb_checker
// watches the stream and config ports of the tile transpose buffer, keeps
// its own copy of the ping-pong store and read/write positions, predicts the
// transposed word for every accepted input item and compares each output item
// field by field against the oldest prediction
// ----------------------------------------------------------------------------
module ttb_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ttb_pkg::CfgIndexBits-1:0] cfg_index,
	input  logic [ttb_pkg::CfgDataBits-1:0]  cfg_data,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [ttb_pkg::InWordBits-1:0]   s_tdata,  // in_word
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [ttb_pkg::OutWordBits-1:0]  m_tdata,  // out_word
	input  logic                             m_tuser,  // out_valid
	input  logic                             m_tlast,  // out_tile_end
	output int                               mismatches,
	output int                               pending
);
	import ttb_pkg::*;

	localparam int MaxRows   = MaxTileRowsDefault;
	localparam int MaxCols   = MaxTileColsDefault;
	localparam int BankWords = MaxRows * MaxCols;

	typedef struct packed {
		logic [OutWordBits-1:0] word;
		logic                   valid;
		logic                   tile_end;
	} xpose_word_t;

	logic [OutWordBits-1:0] tile_mem [0:2*BankWords-1];
	int unsigned rows, cols;
	bit          reverse;
	int unsigned wr_row, wr_col, rd_row, rd_col;
	bit          bank;
	bit          tile_ready;
	xpose_word_t transposed_words [$];

	function automatic int unsigned sat_size(input logic [CfgDataBits-1:0] v,
			input int unsigned hi);
		if (v < MinTileSize) begin
			return MinTileSize;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	function automatic int unsigned slot(input bit b, input int unsigned row,
			input int unsigned col);
		return b * BankWords + row * MaxCols + col;
	endfunction

	function automatic void restart_stream();
		wr_row = 0;
		wr_col = 0;
		rd_row = 0;
		rd_col = 0;
		tile_ready = 1'b0;
	endfunction

	function automatic xpose_word_t transpose_step(input logic [InWordBits-1:0] word);
		xpose_word_t r;
		int unsigned col;
		r = '0;
		if (tile_ready) begin
			col = reverse ? cols - 1 - rd_col : rd_col;
			r.word = tile_mem[slot(~bank, rd_row, col)];
			r.valid = 1'b1;
			if (rd_row + 1 >= rows) begin
				rd_row = 0;
				if (rd_col + 1 >= cols) begin
					rd_col = 0;
					r.tile_end = 1'b1;
				end else begin
					rd_col++;
				end
			end else begin
				rd_row++;
			end
		end
		tile_mem[slot(bank, wr_row, wr_col)] = word;
		if (wr_col + 1 >= cols) begin
			wr_col = 0;
			if (wr_row + 1 >= rows) begin
				wr_row = 0;
				bank = ~bank;
				tile_ready = 1'b1;
				rd_row = 0;
				rd_col = 0;
			end else begin
				wr_row++;
			end
		end else begin
			wr_col++;
		end
		return r;
	endfunction

	task automatic report_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t %s mismatch: expected %h, got %h", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		xpose_word_t want;
		if (!arst_n) begin
			rows = ResetTileSize;
			cols = ResetTileSize;
			reverse = 1'b0;
			bank = 1'b0;
			restart_stream();
			transposed_words.delete();
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TILE_ROWS: begin
						rows = sat_size(cfg_data, MaxRows);
						restart_stream();
					end
					REG_TILE_COLS: begin
						cols = sat_size(cfg_data, MaxCols);
						restart_stream();
					end
					REG_REVERSE_COLUMNS: begin
						reverse = cfg_data[0];
					end
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready) begin
				transposed_words.push_back(transpose_step(s_tdata));
			end
			if (m_tvalid && m_tready) begin
				if (transposed_words.size() == 0) begin
					$display("%0t unexpected item: expected none, got %h/%b/%b",
						$time, m_tdata, m_tuser, m_tlast);
					mismatches++;
				end else begin
					want = transposed_words.pop_front();
					report_field("out_word", want.word, m_tdata);
					report_field("out_valid", want.valid, m_tuser);
					report_field("out_tile_end", want.tile_end, m_tlast);
				end
			end
		end
		pending = transposed_words.size();
	end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the tile transpose buffer: directed corner words,
// then phases of random tiles over several sizes and column orders, with
// random idling on both stream sides, a long output stall and a full drain
// ----------------------------------------------------------------------------
module testbench;
	import ttb_pkg::*;

	localparam int StallLimit = 2000;
	localparam int LongHold   = 80;
	localparam logic [CfgIndexBits-1:0] REG_SPARE = 2'd3;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CfgIndexBits-1:0] cfg_index;
	logic [CfgDataBits-1:0]  cfg_data;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [InWordBits-1:0]   s_tdata;   // in_word
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OutWordBits-1:0]  m_tdata;   // out_word
	logic                    m_tuser;   // out_valid
	logic                    m_tlast;   // out_tile_end
	int                      mismatches;
	int                      pending;
	bit                      idling;
	bit                      hold_request;

	tile_transpose_buffer uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	ttb_checker xpose_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.mismatches(mismatches), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// output side: random stall bursts, plus one long hold on request
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall_left = LongHold - 1;
				m_tready <= 1'b0;
			end else if (idling && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(0, 8);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < StallLimit) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [InWordBits-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 32'h1 << $urandom_range(0, 31);
			3: return ~(32'h1 << $urandom_range(0, 31));
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(input logic [InWordBits-1:0] w);
		s_tdata <= w;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (idling && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
	endtask

	// stop offering items and wait until every predicted item has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIndexBits-1:0] idx,
			input logic [CfgDataBits-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_tiles(input bit sizes, input logic [CfgDataBits-1:0] rows_code,
			input logic [CfgDataBits-1:0] cols_code, input bit rev, input int n);
		drain();
		if (sizes) begin
			write_reg(REG_TILE_ROWS, rows_code);
			write_reg(REG_TILE_COLS, cols_code);
		end
		write_reg(REG_REVERSE_COLUMNS, {6'($urandom), rev});
		repeat (n) send_word(pick_word());
	endtask

	initial begin
		logic [InWordBits-1:0] corner_words [8];
		corner_words = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000,
			32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFF, 32'hFFFF_FFFE};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		idling = 1'b0;
		hold_request = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset sizes: no tile completes yet, outputs stay invalid
		repeat (3) send_word(pick_word());

		// smallest tile, half of it corner words, then a column order flip mid tile
		drain();
		write_reg(REG_TILE_ROWS, 7'd4);
		write_reg(REG_TILE_COLS, 7'd4);
		write_reg(REG_REVERSE_COLUMNS, 7'd0);
		for (int i = 0; i < 16; i++) begin
			send_word(i < 8 ? corner_words[i] : 32'h0101_0101 * i);
		end
		run_tiles(1'b0, 7'd0, 7'd0, 1'b1, 3);
		run_tiles(1'b0, 7'd0, 7'd0, 1'b0, 3);

		idling = 1'b1;
		run_tiles(1'b1, 7'd4, 7'd4, 1'($urandom), 150);
		run_tiles(1'b1, 7'd0, 7'd127, 1'b1, 300);
		run_tiles(1'b1, 7'd127, 7'd3, 1'b0, 300);
		run_tiles(1'b0, 7'd0, 7'd0, 1'b1, 200);

		drain();
		write_reg(REG_SPARE, 7'($urandom));
		for (int p = 0; p < 5; p++) begin
			idling = (p != 2);
			run_tiles(1'b1, 7'($urandom_range(4, 12)), 7'($urandom_range(4, 12)),
				1'($urandom), $urandom_range(80, 150));
		end

		// long output stall while input keeps coming, then a full pause
		idling = 1'b1;
		run_tiles(1'b1, 7'd5, 7'd7, 1'b1, 30);
		hold_request = 1'b1;
		repeat (60) send_word(pick_word());
		drain();
		repeat (60) send_word(pick_word());

		run_tiles(1'b1, 7'd64, 7'd64, 1'b0, 120);

		idling = 1'b0;
		run_tiles(1'b1, 7'd6, 7'd4, 1'b0, 150);

		drain();
		repeat (10) @(negedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
src/ttb_pkg.sv
src/ttb_store.sv
src/ttb_addr_gen.sv
src/tile_transpose_buffer.sv
tb/sv/ttb_checker.sv
tb/sv/testbench.sv
